### rtl/core/edsm_pkg.sv
// ----------------------------------------------------------------------------
// edsm_pkg
// Shared types, constants and tables for the Ed448 scalar mul-add mod L core.
// ----------------------------------------------------------------------------
package edsm_pkg;

	localparam int OPW   = 56;   // operand bytes
	localparam int WIDEW = 114;  // wide value bytes
	localparam int OUTW  = 57;   // result bytes
	localparam int TAILW = 28;   // bytes of c in L = 2^446 - c

	typedef struct packed {
		logic       mode;
		logic [7:0] a_byte;
		logic [7:0] b_byte;
		logic [7:0] c_byte;
		logic       last;
	} edsm_in_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       final_byte;
	} edsm_out_t;

	// datapath operations, one issued per cycle
	typedef enum logic [3:0] {
		OP_NOP     = 4'd0,
		OP_CLR     = 4'd1,   // clear accumulator
		OP_TOP     = 4'd2,   // capture bits 447:446, clear accumulator
		OP_ADD_C   = 4'd3,   // acc += c[ra]
		OP_ADD_W   = 4'd4,   // acc += wide[ra]
		OP_MUL_AB  = 4'd5,   // acc += a[ra] * b[rb]
		OP_MUL_W4C = 4'd6,   // acc += wide[ra] * 4*tail[cidx]
		OP_MUL_TOP = 4'd7,   // acc += top * tail[cidx]
		OP_EMIT    = 4'd8,   // wide[wa] = acc[7:0], acc >>= 8
		OP_BCLR    = 4'd9,   // clear borrow
		OP_SUB     = 4'd10   // wide[wa] = wide[ra] - L[cidx] - borrow
	} edsm_op_t;

	typedef struct packed {
		edsm_op_t   op;
		logic [6:0] ra;
		logic [5:0] rb;
		logic [5:0] cidx;
		logic [6:0] wa;
		logic       src;    // bank read
		logic       dst;    // bank written
		logic       mask;   // keep low 6 bits of the wide byte
		logic       zero;   // operand reads as zero
	} edsm_cmd_t;

	typedef struct packed {
		logic       we;
		logic       first;
		logic [6:0] idx;
	} edsm_ld_t;

	typedef struct packed {
		edsm_cmd_t cmd;
		edsm_ld_t  ld;
		logic      clr_valid;
		logic      out_load;
		logic      out_zero;
	} edsm_ctl_t;

	typedef struct packed {
		logic borrow;
	} edsm_sts_t;

	localparam logic [7:0] TAIL_C [TAILW] = '{
		8'h0d, 8'hbb, 8'ha7, 8'h54, 8'h6d, 8'h3d, 8'h87, 8'hdc,
		8'haa, 8'h70, 8'h3a, 8'h72, 8'h8d, 8'h3d, 8'h93, 8'hde,
		8'h6f, 8'hc9, 8'h29, 8'h51, 8'hb6, 8'h24, 8'hb1, 8'h3b,
		8'h16, 8'hdc, 8'h35, 8'h83
	};

	localparam logic [7:0] ORDER_L [OUTW] = '{
		8'hf3, 8'h44, 8'h58, 8'hab, 8'h92, 8'hc2, 8'h78, 8'h23,
		8'h55, 8'h8f, 8'hc5, 8'h8d, 8'h72, 8'hc2, 8'h6c, 8'h21,
		8'h90, 8'h36, 8'hd6, 8'hae, 8'h49, 8'hdb, 8'h4e, 8'hc4,
		8'he9, 8'h23, 8'hca, 8'h7c, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h3f,
		8'h00
	};

endpackage

### rtl/core/edsm_dp.sv
// ----------------------------------------------------------------------------
// edsm_dp
// Operand memories, two wide banks and a 3-stage byte multiply-accumulate.
// ----------------------------------------------------------------------------
module edsm_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  edsm_pkg::edsm_in_t  item,
	input  edsm_pkg::edsm_ctl_t ctl,
	output edsm_pkg::edsm_sts_t sts,
	output edsm_pkg::edsm_out_t res
);
	import edsm_pkg::*;

	logic [7:0] a_mem  [OPW];
	logic [7:0] b_mem  [OPW];
	logic [7:0] c_mem  [OPW];
	logic [7:0] w0_mem [WIDEW];
	logic [7:0] w1_mem [WIDEW];
	logic [WIDEW-1:0] w0_vld_q;

	logic [7:0] a_rd_s1, b_rd_s1, c_rd_s1, w0_rd_s1, w1_rd_s1;
	logic       w0_vld_s1;
	edsm_cmd_t  cmd_s1, cmd_s2;
	logic [17:0] prod_s2;
	logic [1:0]  top_q;
	logic [23:0] acc_q;
	logic        borrow_q;
	edsm_out_t   out_q;

	logic [7:0]  wide_rd, x;
	logic [9:0]  y;
	logic [23:0] sum;
	logic [8:0]  diff;
	logic        op_load, wide_load, wr_en;
	logic [7:0]  wr_data;

	// operand and wide loads
	assign op_load   = ctl.ld.we && !item.mode && (ctl.ld.idx < 7'(OPW));
	assign wide_load = ctl.ld.we && item.mode && (ctl.ld.idx < 7'(WIDEW));

	always_ff @(posedge clk) begin
		if (op_load) begin
			a_mem[ctl.ld.idx[5:0]] <= item.a_byte;
			b_mem[ctl.ld.idx[5:0]] <= item.b_byte;
			c_mem[ctl.ld.idx[5:0]] <= item.c_byte;
		end
		a_rd_s1 <= a_mem[ctl.cmd.ra[5:0]];
		b_rd_s1 <= b_mem[ctl.cmd.rb];
		c_rd_s1 <= c_mem[ctl.cmd.ra[5:0]];
	end

	// wide banks: bank 0 takes loads and pass results, bank 1 pass results
	always_ff @(posedge clk) begin
		if (wide_load)
			w0_mem[ctl.ld.idx] <= item.a_byte;
		else if (wr_en && !cmd_s2.dst)
			w0_mem[cmd_s2.wa] <= wr_data;
		if (wr_en && cmd_s2.dst)
			w1_mem[cmd_s2.wa] <= wr_data;
		w0_rd_s1 <= w0_mem[ctl.cmd.ra];
		w1_rd_s1 <= w1_mem[ctl.cmd.ra];
	end

	// bank 0 entries not written in this operation read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_vld_q  <= '0;
			w0_vld_s1 <= 1'b0;
		end else begin
			w0_vld_s1 <= w0_vld_q[ctl.cmd.ra];
			if (ctl.clr_valid) begin
				w0_vld_q <= '0;
			end else if (ctl.ld.we) begin
				// first beat always lands at index 0
				if (ctl.ld.first)
					w0_vld_q <= {{(WIDEW-1){1'b0}}, wide_load};
				else if (wide_load)
					w0_vld_q[ctl.ld.idx] <= 1'b1;
			end else if (wr_en && !cmd_s2.dst) begin
				w0_vld_q[cmd_s2.wa] <= 1'b1;
			end
		end
	end

	// stage 1: operand select
	always_comb begin
		wide_rd = cmd_s1.src ? w1_rd_s1 : (w0_vld_s1 ? w0_rd_s1 : 8'h00);
		x = 8'h00;
		y = 10'd0;
		case (cmd_s1.op)
			OP_MUL_AB: begin
				x = a_rd_s1;
				y = {2'b00, b_rd_s1};
			end
			OP_ADD_C: begin
				x = c_rd_s1;
				y = 10'd1;
			end
			OP_ADD_W, OP_SUB: begin
				x = cmd_s1.zero ? 8'h00 :
				    (cmd_s1.mask ? {2'b00, wide_rd[5:0]} : wide_rd);
				y = 10'd1;
			end
			OP_MUL_W4C: begin
				x = wide_rd;
				y = {TAIL_C[cmd_s1.cidx[4:0]], 2'b00};
			end
			OP_MUL_TOP: begin
				x = {6'd0, top_q};
				y = {2'b00, TAIL_C[cmd_s1.cidx[4:0]]};
			end
			default: begin
				x = 8'h00;
				y = 10'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
		end else begin
			cmd_s1 <= ctl.cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= x * y;
		if (cmd_s1.op == OP_TOP)
			top_q <= wide_rd[7:6];
		if (ctl.out_load) begin
			out_q.result_byte <= ctl.out_zero ? 8'h00 : wide_rd;
			out_q.final_byte  <= ctl.out_zero;
		end
	end

	// stage 2: accumulate, emit, subtract
	assign sum  = acc_q + {6'd0, prod_s2};
	assign diff = {1'b0, prod_s2[7:0]} - {1'b0, ORDER_L[cmd_s2.cidx]} - {8'd0, borrow_q};
	assign wr_en   = (cmd_s2.op == OP_EMIT) || (cmd_s2.op == OP_SUB);
	assign wr_data = (cmd_s2.op == OP_SUB) ? diff[7:0] : acc_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			borrow_q <= 1'b0;
		end else begin
			case (cmd_s2.op)
				OP_CLR, OP_TOP: acc_q <= '0;
				OP_ADD_C, OP_ADD_W, OP_MUL_AB, OP_MUL_W4C, OP_MUL_TOP: acc_q <= sum;
				OP_EMIT: acc_q <= {8'd0, acc_q[23:8]};
				OP_BCLR: borrow_q <= 1'b0;
				OP_SUB:  borrow_q <= diff[8];
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign sts.borrow = borrow_q;
	assign res        = out_q;

endmodule

### rtl/core/edsm_ctrl.sv
// ----------------------------------------------------------------------------
// edsm_ctrl
// Sequencer: load count, pass and column loops, drain and result readout.
// ----------------------------------------------------------------------------
module edsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  edsm_pkg::edsm_in_t  item,
	output logic                item_stall,
	output logic                res_valid,
	input  logic                res_stall,
	input  edsm_pkg::edsm_sts_t sts,
	output edsm_pkg::edsm_ctl_t ctl
);
	import edsm_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_INIT     = 10'b0000000010,
		S_ADD      = 10'b0000000100,
		S_MUL      = 10'b0000001000,
		S_EMIT     = 10'b0000010000,
		S_SUB      = 10'b0000100000,
		S_DRAIN    = 10'b0001000000,
		S_OUT_RD   = 10'b0010000000,
		S_OUT_LD   = 10'b0100000000,
		S_OUT_WAIT = 10'b1000000000
	} state_t;

	typedef enum logic [5:0] {
		P_MA  = 6'b000001,
		P_F1  = 6'b000010,
		P_F2  = 6'b000100,
		P_F3  = 6'b001000,
		P_FT  = 6'b010000,
		P_SUB = 6'b100000
	} pass_t;

	state_t     state_q;
	pass_t      pass_q;
	logic [6:0] lc_q, k_q;
	logic [5:0] j_q, ocnt_q;
	logic [1:0] dcnt_q;
	logic       obank_q;

	logic [6:0] lo, hi, k_last;
	logic       has_add, has_mul, fsrc, fdst;

	// column bounds of the current pass
	always_comb begin
		lo      = '0;
		hi      = '0;
		has_add = 1'b0;
		has_mul = 1'b0;
		k_last  = '0;
		case (pass_q)
			P_MA: begin
				lo      = (k_q > 7'(OPW-1)) ? k_q - 7'(OPW-1) : 7'd0;
				hi      = (k_q > 7'(OPW-1)) ? 7'(OPW-1) : k_q;
				has_add = k_q < 7'(OPW);
				has_mul = lo <= hi;
				k_last  = 7'(2*OPW-1);
			end
			P_F1, P_F2, P_F3: begin
				lo      = (k_q > 7'(WIDEW-OPW-1)) ? k_q - 7'(WIDEW-OPW-1) : 7'd0;
				hi      = (k_q > 7'(TAILW-1)) ? 7'(TAILW-1) : k_q;
				has_add = k_q < 7'(OPW);
				has_mul = lo <= hi;
				k_last  = 7'(WIDEW-1);
			end
			P_FT: begin
				lo      = k_q;
				hi      = k_q;
				has_add = 1'b1;
				has_mul = k_q < 7'(TAILW);
				k_last  = 7'(OPW-1);
			end
			P_SUB:   k_last = 7'(OUTW-1);
			default: k_last = '0;
		endcase
	end

	assign fsrc = (pass_q == P_F2) || (pass_q == P_FT);
	assign fdst = (pass_q == P_F1) || (pass_q == P_F3);

	// command issue
	always_comb begin
		ctl = '0;
		ctl.cmd.op = OP_NOP;
		case (state_q)
			S_IDLE: begin
				ctl.ld.we    = item_valid;
				ctl.ld.first = lc_q == 7'd0;
				ctl.ld.idx   = lc_q;
			end
			S_INIT: begin
				case (pass_q)
					P_MA: begin
						ctl.cmd.op    = OP_CLR;
						ctl.clr_valid = 1'b1;
					end
					P_FT: begin
						ctl.cmd.op  = OP_TOP;
						ctl.cmd.ra  = 7'(OPW-1);
						ctl.cmd.src = 1'b1;
					end
					P_SUB:   ctl.cmd.op = OP_BCLR;
					default: ctl.cmd.op = OP_CLR;
				endcase
			end
			S_ADD: begin
				if (has_add) begin
					ctl.cmd.ra   = k_q;
					ctl.cmd.src  = fsrc;
					ctl.cmd.op   = (pass_q == P_MA) ? OP_ADD_C : OP_ADD_W;
					ctl.cmd.mask = (pass_q == P_FT) && (k_q == 7'(OPW-1));
				end
			end
			S_MUL: begin
				ctl.cmd.cidx = j_q;
				ctl.cmd.src  = fsrc;
				case (pass_q)
					P_MA: begin
						ctl.cmd.op = OP_MUL_AB;
						ctl.cmd.ra = {1'b0, j_q};
						ctl.cmd.rb = 6'(k_q - {1'b0, j_q});
					end
					P_FT:    ctl.cmd.op = OP_MUL_TOP;
					default: begin
						ctl.cmd.op = OP_MUL_W4C;
						ctl.cmd.ra = 7'(k_q + 7'(OPW) - {1'b0, j_q});
					end
				endcase
			end
			S_EMIT: begin
				ctl.cmd.op  = OP_EMIT;
				ctl.cmd.wa  = k_q;
				ctl.cmd.dst = fdst;
			end
			S_SUB: begin
				ctl.cmd.op   = OP_SUB;
				ctl.cmd.ra   = k_q;
				ctl.cmd.wa   = k_q;
				ctl.cmd.cidx = k_q[5:0];
				ctl.cmd.dst  = 1'b1;
				ctl.cmd.zero = k_q == 7'(OUTW-1);
			end
			S_OUT_RD: begin
				ctl.cmd.ra  = {1'b0, ocnt_q};
				ctl.cmd.src = obank_q;
			end
			S_OUT_LD: begin
				ctl.out_load = 1'b1;
				ctl.out_zero = ocnt_q == 6'(OUTW-1);
			end
			default: ctl.cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= P_MA;
			lc_q    <= '0;
			k_q     <= '0;
			j_q     <= '0;
			ocnt_q  <= '0;
			dcnt_q  <= '0;
			obank_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (item.last) begin
							lc_q    <= '0;
							k_q     <= '0;
							pass_q  <= item.mode ? P_F1 : P_MA;
							state_q <= S_INIT;
						end else if (lc_q < 7'(WIDEW)) begin
							lc_q <= lc_q + 7'd1;
						end
					end
				end
				S_INIT: begin
					k_q     <= '0;
					state_q <= (pass_q == P_SUB) ? S_SUB : S_ADD;
				end
				S_ADD: begin
					j_q     <= lo[5:0];
					state_q <= has_mul ? S_MUL : S_EMIT;
				end
				S_MUL: begin
					if ({1'b0, j_q} == hi)
						state_q <= S_EMIT;
					else
						j_q <= j_q + 6'd1;
				end
				S_EMIT, S_SUB: begin
					if (k_q == k_last) begin
						dcnt_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						k_q     <= k_q + 7'd1;
						state_q <= (state_q == S_SUB) ? S_SUB : S_ADD;
					end
				end
				S_DRAIN: begin
					// let the last writes leave the pipeline
					if (dcnt_q == 2'd2) begin
						k_q <= '0;
						case (pass_q)
							P_MA: begin
								pass_q  <= P_F1;
								state_q <= S_INIT;
							end
							P_F1: begin
								pass_q  <= P_F2;
								state_q <= S_INIT;
							end
							P_F2: begin
								pass_q  <= P_F3;
								state_q <= S_INIT;
							end
							P_F3: begin
								pass_q  <= P_FT;
								state_q <= S_INIT;
							end
							P_FT: begin
								pass_q  <= P_SUB;
								state_q <= S_INIT;
							end
							default: begin
								obank_q <= !sts.borrow;
								ocnt_q  <= '0;
								state_q <= S_OUT_RD;
							end
						endcase
					end else begin
						dcnt_q <= dcnt_q + 2'd1;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: state_q <= S_OUT_WAIT;
				S_OUT_WAIT: begin
					if (!res_stall) begin
						if (ocnt_q == 6'(OUTW-1)) begin
							state_q <= S_IDLE;
						end else begin
							ocnt_q  <= ocnt_q + 6'd1;
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_stall = state_q != S_IDLE;
	assign res_valid  = state_q == S_OUT_WAIT;

endmodule

### rtl/core/ed448_scalar_muladd_mod_l.sv
// ----------------------------------------------------------------------------
// ed448_scalar_muladd_mod_l
// Ed448 scalar a*b+c mod L, or reduction of a 114-byte value mod L.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one beat per operand byte,
//   little-endian. Mode 0 beats carry a, b and c bytes (first 56 used), mode 1
//   beats carry the wide value in a_byte (first 114 used). The beat with last
//   set starts the computation; its mode selects the operation.
//   res channel (res_valid / res_stall / res): 57 beats of result_byte, the
//   last with final_byte set and a zero byte.
// Sequence:
//   Load beats are accepted back to back while idle. After the last beat a
//   single byte MAC runs the passes in order: mul-add (mode 0 only), three
//   folds by 4c, a final fold and a subtract of L. Each result beat then
//   goes through read, load and wait states, so result beats are not back
//   to back. The MAC, shared by all passes, takes one product per cycle.
//   item_stall stays high from the last beat until the final result beat is
//   taken. A stalled result beat holds until accepted.
// Reset: arst_n clears the sequencer and the load count; the block is then
//   ready for a fresh operation. Operand stores are not cleared.
// ----------------------------------------------------------------------------
module ed448_scalar_muladd_mod_l (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  edsm_pkg::edsm_in_t item,
	output logic               res_valid,
	input  logic               res_stall,
	output edsm_pkg::edsm_out_t res
);
	import edsm_pkg::*;

	edsm_ctl_t ctl;
	edsm_sts_t sts;

	// sequencer
	edsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sts        (sts),
		.ctl        (ctl)
	);

	// stores and MAC datapath
	edsm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.res    (res)
	);

`ifndef SYNTHESIS
	// never load and deliver at once
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |-> !res_valid)
		else $error("input accepted while a result beat is pending");

	// after the final beat the block is ready again
	a_ready_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && res.final_byte |=> !item_stall)
		else $error("block not ready after final result beat");

	// the top result byte is always zero
	a_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.final_byte |-> res.result_byte == 8'h00)
		else $error("final result byte not zero");
`endif

endmodule
